### hdl/fda_pkg.sv
// Shared constants, types and the arctangent table of the fisheye dewarp address generator.
// Used by every file in this folder; depends on nothing.
package fda_pkg;

    localparam int RADIUS   = 700;
    localparam int N_PIX    = 2 * RADIUS;
    localparam int CENTER_RESET = 740;
    localparam int CFG_W    = 12;

    localparam int PI_Q      = 205887;
    localparam int HALF_PI_Q = 102944;
    localparam int GAIN_Q    = 39797;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 17;
    localparam int DIV_STEPS    = 17;
    localparam int CSTEP_W      = $clog2(CORDIC_STEPS);
    localparam int SSTEP_W      = $clog2(SQRT_STEPS);

    // reciprocals for division by constants
    localparam longint RECIP_N  = (64'd1 << 32) / N_PIX;
    localparam longint RECIP_PI = (64'd1 << 48) / PI_Q;

    typedef enum logic [0:0] {
        CFG_CENTER_X = 1'b0,
        CFG_CENTER_Y = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [20:0] x;
        logic signed [20:0] y;
        logic signed [19:0] z;
    } t_cordic;

    typedef struct packed {
        logic [33:0] rem;
        logic [34:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [16:0] p;
        logic [16:0] dv;
        logic [16:0] q;
    } t_div;

    function automatic logic signed [19:0] atan_lut(input logic [CSTEP_W-1:0] k);
        logic signed [19:0] v;
        case (k)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

endpackage

### hdl/fda_cordic_cell.sv
// One CORDIC micro-rotation stage, rotation or vectoring mode, registered.
// Depends on fda_pkg.
module fda_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [fda_pkg::CSTEP_W-1:0]   i_step,
    input  logic                          i_vec,
    input  fda_pkg::t_cordic              i_d,
    output fda_pkg::t_cordic              o_q
);
    import fda_pkg::*;

    logic               sigma;
    logic signed [20:0] xs;
    logic signed [20:0] ys;
    logic signed [19:0] ang;
    t_cordic            n_q;
    t_cordic            r_q;

    always_comb begin
        sigma = i_vec ? i_d.y[20] : !i_d.z[19];
        xs    = i_d.x >>> i_step;
        ys    = i_d.y >>> i_step;
        ang   = atan_lut(i_step);
        if (sigma) begin
            n_q.x = i_d.x - ys;
            n_q.y = i_d.y + xs;
            n_q.z = i_d.z - ang;
        end else begin
            n_q.x = i_d.x + ys;
            n_q.y = i_d.y - xs;
            n_q.z = i_d.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### hdl/fda_sqrt_cell.sv
// One bit-pair step of the integer square root, registered.
// Depends on fda_pkg.
module fda_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [fda_pkg::SSTEP_W-1:0]   i_step,
    input  fda_pkg::t_sqrt                i_d,
    output fda_pkg::t_sqrt                o_q
);
    import fda_pkg::*;

    logic [5:0]  sh;
    logic [34:0] bitv;
    logic [34:0] trial;
    t_sqrt       n_q;
    t_sqrt       r_q;

    always_comb begin
        sh    = 6'(2 * (SQRT_STEPS - 1)) - {i_step, 1'b0};
        bitv  = 35'd1 << sh;
        trial = i_d.root + bitv;
        if ({1'b0, i_d.rem} >= trial) begin
            n_q.rem  = 34'({1'b0, i_d.rem} - trial);
            n_q.root = (i_d.root >> 1) + bitv;
        end else begin
            n_q.rem  = i_d.rem;
            n_q.root = i_d.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### hdl/fda_div_cell.sv
// One restoring-division step: one quotient bit per cell, registered.
// Depends on fda_pkg.
module fda_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [16:0]   i_div,
    input  fda_pkg::t_div i_d,
    output fda_pkg::t_div o_q
);
    import fda_pkg::*;

    logic [17:0] p2;
    logic        ge;
    t_div        n_q;
    t_div        r_q;

    always_comb begin
        p2      = {i_d.p, i_d.dv[16]};
        ge      = p2 >= {1'b0, i_div};
        n_q.p   = ge ? 17'(p2 - {1'b0, i_div}) : p2[16:0];
        n_q.dv  = {i_d.dv[15:0], 1'b0};
        n_q.q   = {i_d.q[15:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### hdl/fisheye_dewarp_address_gen.sv
// Fisheye double-longitude dewarp address generator, top level.
// Depends on fda_pkg, fda_cordic_cell, fda_sqrt_cell, fda_div_cell.
//
// Usage:
//   Slave stream carries one corrected-image pixel per transfer
//   (tdata: out_row [10:0], out_col [21:11]). Master stream returns one
//   source address per transfer (tdata: src_x [11:0], src_y [23:12];
//   tuser: hit). A miss (out of range, degenerate corner, outside the
//   crop) gives hit = 0 with both addresses 0.
//   Configuration: write center_x (index 0) or center_y (index 1) through
//   i_cfg_wr_en / i_cfg_index / i_cfg_data while the stream is idle.
//   Throughput: one transfer per cycle while the output buffer is not
//   full, fully pipelined. The pipeline is built from 16-step CORDIC rows
//   for sin/cos and atan, 17-step square root and divider rows, and the
//   constant-divide and multiply stages around them.
//   Output stage is a two-entry buffer; the pipeline freezes only when
//   both entries hold untaken results, so input is still accepted while
//   one result waits.
//   Reset clears the pipeline valids and the buffer and sets both centers
//   to 740.
module fisheye_dewarp_address_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  fda_pkg::t_cfg_reg           i_cfg_index,
    input  logic [fda_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,   // out_row[10:0], out_col[21:11]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // src_x[11:0], src_y[23:12]
    output logic                        m_axis_tuser    // hit[0]
);
    import fda_pkg::*;

    localparam int LAST = 69;

    logic en;
    logic push;
    logic pop;

    logic [11:0] r_cx;
    logic [11:0] r_cy;

    logic [LAST:0] r_vld;
    logic [LAST:1] r_ok;
    logic [LAST:1] n_ok;

    // front stages
    logic [10:0] r0_row, r0_col;
    logic        ok1;
    logic [11:0] r1_jp1, r1_ip1;
    logic [29:0] r2_va, r2_vb;
    logic [59:0] prod_a, prod_b;
    logic [17:0] r3_q0a, r3_q0b;
    logic [29:0] r3_va, r3_vb;
    logic [29:0] rem_a, rem_b;
    logic [17:0] qa, qb;
    logic signed [19:0] r4_za, r4_zb;
    logic signed [19:0] fz_a, fz_b;
    logic        fneg_a, fneg_b;
    t_cordic     r5_ca, r5_cb;
    logic [21:5] r_nega, r_negb;
    t_cordic     c_a [0:CORDIC_STEPS];
    t_cordic     c_b [0:CORDIC_STEPS];

    // products and square root
    logic signed [20:0] r22_sa, r22_ca, r22_sb, r22_cb;
    logic signed [41:0] pu, pd;
    logic signed [19:0] r23_u, r23_d;
    logic signed [20:0] r23_ca;
    logic signed [39:0] puu;
    logic signed [41:0] pcc;
    logic [33:0] r24_uu, r24_cc;
    logic signed [19:0] r_u  [24:42];
    logic signed [19:0] r_ca [24:42];
    logic signed [19:0] r_d  [24:42];
    t_sqrt       r25_sq;
    t_sqrt       sq [0:SQRT_STEPS];

    // division and atan
    logic [16:0] s_root;
    logic [19:0] abs_u, abs_c;
    t_div        r43_du, r43_dc;
    t_cordic     r43_at;
    logic [16:0] r_s [43:59];
    logic [60:43] r_sgnu, r_sgnc;
    t_div        dvu [0:DIV_STEPS];
    t_div        dvc [0:DIV_STEPS];
    t_cordic     at  [0:CORDIC_STEPS];

    // back stages
    logic [16:0] r60_th;
    logic signed [17:0] r_cf [61:67];
    logic signed [17:0] r_sf [61:67];
    logic [28:0] r61_t;
    logic [59:0] prod_t;
    logic [11:0] r62_q0;
    logic [28:0] r62_t;
    logic [18:0] r63_r0;
    logic [11:0] r63_q0;
    logic        ge64;
    logic [12:0] r64_q;
    logic [17:0] r64_r;
    logic [48:0] prod_r;
    logic [16:0] r65_f0;
    logic [17:0] r65_r;
    logic [12:0] r65_q;
    logic [35:0] e66;
    logic [18:0] r66_e;
    logic [16:0] r66_f0;
    logic [12:0] r66_q;
    logic [28:0] r67_rho;
    logic signed [47:0] r68_px, r68_py;
    logic signed [32:0] xx, xy;
    logic signed [32:0] nxx, nxy;
    logic signed [16:0] r69_ix, r69_iy;

    // output
    logic               inb;
    logic signed [18:0] sx, sy;
    logic [11:0]        sx_sat, sy_sat;
    logic [11:0]        r_fx [0:1];
    logic [11:0]        r_fy [0:1];
    logic               r_fh [0:1];
    logic               r_wr, r_rd;
    logic [1:0]         r_cnt;

    assign en            = (r_cnt != 2'd2);
    assign s_axis_tready = en;
    assign push          = en && r_vld[LAST];
    assign pop           = m_axis_tvalid && m_axis_tready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= 12'(CENTER_RESET);
            r_cy <= 12'(CENTER_RESET);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_cx <= i_cfg_data;
                CFG_CENTER_Y: r_cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid and in-range flags
    always_comb begin
        ok1      = (12'(r0_row) < 12'(N_PIX)) && (12'(r0_col) < 12'(N_PIX));
        s_root   = sq[SQRT_STEPS].root[16:0];
        n_ok     = {r_ok[LAST-1:1], ok1};
        n_ok[43] = r_ok[42] && (s_root != 17'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ok  <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], s_axis_tvalid};
            r_ok  <= n_ok;
        end
    end

    // angle setup
    always_comb begin
        prod_a = 60'(r2_va) * 60'(RECIP_N);
        prod_b = 60'(r2_vb) * 60'(RECIP_N);
        rem_a  = r3_va - 30'(r3_q0a) * 30'(N_PIX);
        rem_b  = r3_vb - 30'(r3_q0b) * 30'(N_PIX);
        qa     = r3_q0a + 18'(rem_a >= 30'(N_PIX));
        qb     = r3_q0b + 18'(rem_b >= 30'(N_PIX));
        fz_a   = r4_za;
        fneg_a = 1'b0;
        if (r4_za > 20'(HALF_PI_Q)) begin
            fz_a   = 20'(PI_Q) - r4_za;
            fneg_a = 1'b1;
        end else if (r4_za < -20'(HALF_PI_Q)) begin
            fz_a   = -20'(PI_Q) - r4_za;
            fneg_a = 1'b1;
        end
        fz_b   = r4_zb;
        fneg_b = 1'b0;
        if (r4_zb > 20'(HALF_PI_Q)) begin
            fz_b   = 20'(PI_Q) - r4_zb;
            fneg_b = 1'b1;
        end else if (r4_zb < -20'(HALF_PI_Q)) begin
            fz_b   = -20'(PI_Q) - r4_zb;
            fneg_b = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_row <= s_axis_tdata[10:0];
            r0_col <= s_axis_tdata[21:11];
            r1_jp1 <= 12'(N_PIX) - 12'(r0_row);
            r1_ip1 <= 12'(N_PIX) - 12'(r0_col);
            r2_va  <= 30'(r1_jp1) * 30'(PI_Q) + 30'(RADIUS);
            r2_vb  <= 30'(r1_ip1) * 30'(PI_Q) + 30'(RADIUS);
            r3_q0a <= prod_a[49:32];
            r3_q0b <= prod_b[49:32];
            r3_va  <= r2_va;
            r3_vb  <= r2_vb;
            r4_za  <= signed'({2'b00, qa});
            r4_zb  <= 20'(HALF_PI_Q) - signed'({2'b00, qb});
            r5_ca  <= '{x: 21'(GAIN_Q), y: '0, z: fz_a};
            r5_cb  <= '{x: 21'(GAIN_Q), y: '0, z: fz_b};
            r_nega <= {r_nega[20:5], fneg_a};
            r_negb <= {r_negb[20:5], fneg_b};
        end
    end

    // sin/cos rows
    assign c_a[0] = r5_ca;
    assign c_b[0] = r5_cb;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_sincos
        fda_cordic_cell u_cell_a (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_step (CSTEP_W'(k)),
            .i_vec  (1'b0),
            .i_d    (c_a[k]),
            .o_q    (c_a[k+1])
        );
        fda_cordic_cell u_cell_b (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_step (CSTEP_W'(k)),
            .i_vec  (1'b0),
            .i_d    (c_b[k]),
            .o_q    (c_b[k+1])
        );
    end

    // u, d and the radicand
    always_comb begin
        pu  = r22_sa * r22_sb;
        pd  = r22_sa * r22_cb;
        puu = r23_u * r23_u;
        pcc = r23_ca * r23_ca;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r22_sa <= c_a[CORDIC_STEPS].y;
            r22_ca <= r_nega[21] ? -c_a[CORDIC_STEPS].x : c_a[CORDIC_STEPS].x;
            r22_sb <= c_b[CORDIC_STEPS].y;
            r22_cb <= r_negb[21] ? -c_b[CORDIC_STEPS].x : c_b[CORDIC_STEPS].x;
            r23_u  <= pu[35:16];
            r23_d  <= pd[41] ? 20'sd0 : pd[35:16];
            r23_ca <= r22_ca;
            r24_uu <= puu[33:0];
            r24_cc <= pcc[33:0];
            r_u[24]  <= r23_u;
            r_ca[24] <= r23_ca[19:0];
            r_d[24]  <= r23_d;
            for (int k = 25; k <= 42; k++) begin
                r_u[k]  <= r_u[k-1];
                r_ca[k] <= r_ca[k-1];
                r_d[k]  <= r_d[k-1];
            end
            r25_sq <= '{rem: r24_uu + r24_cc, root: '0};
        end
    end

    // square root row
    assign sq[0] = r25_sq;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        fda_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_step (SSTEP_W'(k)),
            .i_d    (sq[k]),
            .o_q    (sq[k+1])
        );
    end

    // divider and atan setup
    always_comb begin
        abs_u = r_u[42][19]  ? 20'(-r_u[42])  : 20'(r_u[42]);
        abs_c = r_ca[42][19] ? 20'(-r_ca[42]) : 20'(r_ca[42]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r43_du <= '{p: {1'b0, abs_u[16:1]}, dv: {abs_u[0], 16'd0}, q: '0};
            r43_dc <= '{p: {1'b0, abs_c[16:1]}, dv: {abs_c[0], 16'd0}, q: '0};
            r43_at <= '{x: 21'(r_d[42]), y: signed'({4'd0, s_root}), z: '0};
            r_s[43] <= s_root;
            for (int k = 44; k <= 59; k++) begin
                r_s[k] <= r_s[k-1];
            end
            r_sgnu <= {r_sgnu[59:43], r_u[42][19]};
            r_sgnc <= {r_sgnc[59:43], r_ca[42][19]};
        end
    end

    assign dvu[0] = r43_du;
    assign dvc[0] = r43_dc;
    assign at[0]  = r43_at;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        fda_div_cell u_cell_u (
            .i_clk (i_clk),
            .i_en  (en),
            .i_div (r_s[43+k]),
            .i_d   (dvu[k]),
            .o_q   (dvu[k+1])
        );
        fda_div_cell u_cell_c (
            .i_clk (i_clk),
            .i_en  (en),
            .i_div (r_s[43+k]),
            .i_d   (dvc[k]),
            .o_q   (dvc[k+1])
        );
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_atan
        fda_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_step (CSTEP_W'(k)),
            .i_vec  (1'b1),
            .i_d    (at[k]),
            .o_q    (at[k+1])
        );
    end

    // rho = theta * 2R * 65536 / pi, split as t / pi and remainder
    always_comb begin
        prod_t = 60'(r61_t) * 60'(RECIP_PI);
        ge64   = r63_r0 >= 19'(PI_Q);
        prod_r = 49'(r64_r) * 49'(RECIP_PI);
        e66    = {2'b00, r65_r, 16'd0} - 36'(r65_f0) * 36'(PI_Q);
        xx     = 33'(signed'(r68_px[47:16])) + 33'(RADIUS * 65536);
        xy     = 33'(signed'(r68_py[47:16])) + 33'(RADIUS * 65536);
        nxx    = -xx;
        nxy    = -xy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r60_th  <= at[CORDIC_STEPS].z[19] ? 17'd0 : at[CORDIC_STEPS].z[16:0];
            r_cf[61] <= r_sgnu[60] ? -signed'({1'b0, dvu[DIV_STEPS].q})
                                   :  signed'({1'b0, dvu[DIV_STEPS].q});
            r_sf[61] <= r_sgnc[60] ? -signed'({1'b0, dvc[DIV_STEPS].q})
                                   :  signed'({1'b0, dvc[DIV_STEPS].q});
            for (int k = 62; k <= 67; k++) begin
                r_cf[k] <= r_cf[k-1];
                r_sf[k] <= r_sf[k-1];
            end
            r61_t   <= 29'(r60_th) * 29'(N_PIX);
            r62_q0  <= prod_t[59:48];
            r62_t   <= r61_t;
            r63_r0  <= 19'(30'(r62_t) - 30'(r62_q0) * 30'(PI_Q));
            r63_q0  <= r62_q0;
            r64_q   <= 13'(r63_q0) + 13'(ge64);
            r64_r   <= ge64 ? 18'(r63_r0 - 19'(PI_Q)) : r63_r0[17:0];
            r65_f0  <= prod_r[48:32];
            r65_r   <= r64_r;
            r65_q   <= r64_q;
            r66_e   <= e66[18:0];
            r66_f0  <= r65_f0;
            r66_q   <= r65_q;
            r67_rho <= {r66_q, 16'd0} + 29'(r66_f0) + 29'(r66_e >= 19'(PI_Q));
            r68_px  <= signed'({1'b0, r67_rho}) * r_cf[67];
            r68_py  <= signed'({1'b0, r67_rho}) * r_sf[67];
            r69_ix  <= xx[32] ? -signed'(nxx[32:16]) : signed'(xx[32:16]);
            r69_iy  <= xy[32] ? -signed'(nxy[32:16]) : signed'(xy[32:16]);
        end
    end

    // bounds, offset and saturation
    always_comb begin
        inb = r_ok[LAST] && !r69_ix[16] && !r69_iy[16]
              && (r69_ix < 17'(N_PIX)) && (r69_iy < 17'(N_PIX));
        sx  = 19'(r69_ix) + signed'(19'(r_cx)) - 19'(RADIUS);
        sy  = 19'(r69_iy) + signed'(19'(r_cy)) - 19'(RADIUS);
        if (sx < 19'sd0) begin
            sx_sat = 12'd0;
        end else if (sx > 19'sd4095) begin
            sx_sat = 12'hFFF;
        end else begin
            sx_sat = sx[11:0];
        end
        if (sy < 19'sd0) begin
            sy_sat = 12'd0;
        end else if (sy > 19'sd4095) begin
            sy_sat = 12'hFFF;
        end else begin
            sy_sat = sy[11:0];
        end
    end

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fx[r_wr] <= inb ? sx_sat : 12'd0;
            r_fy[r_wr] <= inb ? sy_sat : 12'd0;
            r_fh[r_wr] <= inb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {r_fy[r_rd], r_fx[r_rd]};
    assign m_axis_tuser  = r_fh[r_rd];

    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("miss result carries a nonzero address");

    a_range_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[0] && ((12'(r0_row) >= 12'(N_PIX)) || (12'(r0_col) >= 12'(N_PIX)))
        |=> !r_ok[1])
        else $error("out-of-range pixel not flagged");

    a_zero_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[42] && (sq[SQRT_STEPS].root[16:0] == 17'd0) |=> !r_ok[43])
        else $error("degenerate corner not flagged");

    a_buf_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !pop |=> r_cnt == 2'd2 && !push)
        else $error("output buffer overrun");

endmodule
